// File: hdl/koon_pkg.sv
// Shared constants, types and the control store for the k-out-of-n reliability block.
// Used by identical_koon_reliability and koon_chk; depends on nothing.
package koon_pkg;

    localparam int MAX_COMPONENTS = 32;
    localparam int FRAC_BITS      = 16;
    localparam int XW             = FRAC_BITS + 1;           // Q1.16 value width
    localparam int CNT_W          = 6;                       // holds 0..MAX_COMPONENTS
    localparam int ROW_LEN        = MAX_COMPONENTS + 1;
    localparam int ADDR_W         = $clog2(ROW_LEN);
    localparam int COEF_W         = 30;                      // C(32,16) < 2^30
    localparam int PROD_W         = COEF_W + XW;
    localparam int ACC_W          = FRAC_BITS + MAX_COMPONENTS + 1;
    localparam int DATA_W         = 24;                      // XW padded to bytes
    localparam int CFG_AW         = 2;
    localparam int CFG_DW         = 6;
    localparam int UPC_W          = 5;

    localparam logic [XW-1:0]     FX_ONE   = XW'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_COMPONENTS);
    localparam logic [CNT_W-1:0]  N_RESET  = CNT_W'(2);
    localparam logic [CNT_W-1:0]  K_RESET  = CNT_W'(1);

    // register indexes of the configuration port
    localparam logic [CFG_AW-1:0] CFG_COMPONENT_COUNT = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] CFG_MIN_WORKING     = CFG_AW'(1);

    typedef logic [UPC_W-1:0] t_upc;

    // program addresses
    localparam t_upc S_IDLE    = t_upc'(0);
    localparam t_upc S_A_START = t_upc'(1);
    localparam t_upc S_A_MUL   = t_upc'(2);
    localparam t_upc S_A_WB    = t_upc'(3);
    localparam t_upc S_B_INIT  = t_upc'(4);
    localparam t_upc S_B_TEST  = t_upc'(5);
    localparam t_upc S_B_P     = t_upc'(6);
    localparam t_upc S_B_C     = t_upc'(7);
    localparam t_upc S_B_ACC   = t_upc'(8);
    localparam t_upc S_B_SKIP  = t_upc'(9);
    localparam t_upc S_B_RWB   = t_upc'(10);
    localparam t_upc S_DONE    = t_upc'(11);
    localparam t_upc S_L_SEED  = t_upc'(12);
    localparam t_upc S_L_ROW   = t_upc'(13);
    localparam t_upc S_L_RD    = t_upc'(14);
    localparam t_upc S_L_WR    = t_upc'(15);
    localparam t_upc S_L_END   = t_upc'(16);

    typedef enum logic [2:0] {
        C_ALWAYS, C_ACCEPT, C_I_EQ_N, C_W_LT_K, C_W_EQ_N, C_W_EQ_I, C_OUT_FREE
    } t_cond;
    typedef enum logic       {MA_PW, MA_COEF}                  t_mula;
    typedef enum logic [1:0] {MB_U, MB_R, MB_PU, MB_PFRAC}     t_mulb;
    typedef enum logic [1:0] {PW_HOLD, PW_ONE, PW_PFRAC}       t_pwop;
    typedef enum logic       {I_HOLD, I_INC}                   t_iop;
    typedef enum logic [1:0] {W_HOLD, W_ZERO, W_ONE, W_INC}    t_wop;
    typedef enum logic [1:0] {CY_HOLD, CY_ONE, CY_OLD}         t_cyop;
    typedef enum logic       {CS_ONE, CS_SUM}                  t_coefsrc;
    typedef enum logic       {PS_PW, PS_PFRAC}                 t_pusrc;

    typedef struct packed {
        t_cond    cond;
        t_upc     jt;        // taken when cond holds
        t_upc     jf;        // taken otherwise
        logic     mul_en;
        t_mula    mula;
        t_mulb    mulb;
        t_pwop    pw_op;
        t_iop     i_op;
        t_wop     w_op;
        t_cyop    cy_op;
        logic     coef_we;
        t_coefsrc coef_src;
        logic     pu_we;
        t_pusrc   pu_src;
        logic     acc_add;
        logic     out_load;
    } t_uword;

    // control store
    function automatic t_uword f_ucode(input t_upc a);
        t_uword uw;
        uw = '0;
        unique case (a)
            S_IDLE: begin
                uw.cond = C_ACCEPT; uw.jt = S_A_START; uw.jf = S_IDLE;
            end
            S_A_START: begin
                uw.pu_we = 1'b1; uw.pu_src = PS_PW;
                uw.jt = S_A_MUL; uw.jf = S_A_MUL;
            end
            S_A_MUL: begin
                uw.mul_en = 1'b1; uw.mula = MA_PW; uw.mulb = MB_U; uw.i_op = I_INC;
                uw.jt = S_A_WB; uw.jf = S_A_WB;
            end
            S_A_WB: begin
                uw.pw_op = PW_PFRAC; uw.pu_we = 1'b1; uw.pu_src = PS_PFRAC;
                uw.cond = C_I_EQ_N; uw.jt = S_B_INIT; uw.jf = S_A_MUL;
            end
            S_B_INIT: begin
                uw.pw_op = PW_ONE; uw.w_op = W_ZERO;
                uw.jt = S_B_TEST; uw.jf = S_B_TEST;
            end
            S_B_TEST: begin
                uw.cond = C_W_LT_K; uw.jt = S_B_SKIP; uw.jf = S_B_P;
            end
            S_B_P: begin
                uw.mul_en = 1'b1; uw.mula = MA_PW; uw.mulb = MB_PU;
                uw.jt = S_B_C; uw.jf = S_B_C;
            end
            S_B_C: begin
                uw.mul_en = 1'b1; uw.mula = MA_COEF; uw.mulb = MB_PFRAC;
                uw.jt = S_B_ACC; uw.jf = S_B_ACC;
            end
            S_B_ACC: begin
                uw.acc_add = 1'b1;
                uw.mul_en = 1'b1; uw.mula = MA_PW; uw.mulb = MB_R;
                uw.cond = C_W_EQ_N; uw.jt = S_DONE; uw.jf = S_B_RWB;
            end
            S_B_SKIP: begin
                uw.mul_en = 1'b1; uw.mula = MA_PW; uw.mulb = MB_R;
                uw.cond = C_W_EQ_N; uw.jt = S_DONE; uw.jf = S_B_RWB;
            end
            S_B_RWB: begin
                uw.pw_op = PW_PFRAC; uw.w_op = W_INC;
                uw.jt = S_B_TEST; uw.jf = S_B_TEST;
            end
            S_DONE: begin
                uw.out_load = 1'b1;
                uw.cond = C_OUT_FREE; uw.jt = S_IDLE; uw.jf = S_DONE;
            end
            S_L_SEED: begin
                uw.coef_we = 1'b1; uw.coef_src = CS_ONE;
                uw.jt = S_L_ROW; uw.jf = S_L_ROW;
            end
            S_L_ROW: begin
                uw.i_op = I_INC; uw.w_op = W_ONE; uw.cy_op = CY_ONE;
                uw.jt = S_L_RD; uw.jf = S_L_RD;
            end
            S_L_RD: begin
                uw.jt = S_L_WR; uw.jf = S_L_WR;
            end
            S_L_WR: begin
                uw.coef_we = 1'b1; uw.coef_src = CS_SUM; uw.cy_op = CY_OLD;
                uw.w_op = W_INC;
                uw.cond = C_W_EQ_I; uw.jt = S_L_END; uw.jf = S_L_RD;
            end
            S_L_END: begin
                uw.cond = C_I_EQ_N; uw.jt = S_IDLE; uw.jf = S_L_ROW;
            end
            default: begin
                uw.jt = S_IDLE; uw.jf = S_IDLE;
            end
        endcase
        return uw;
    endfunction

    // written counts: zero reads as one, anything above the maximum as the maximum
    function automatic logic [CNT_W-1:0] f_clamp_cfg(input logic [CFG_DW-1:0] v);
        logic [CNT_W-1:0] c;
        c = CNT_W'(v);
        if (v == '0) begin
            c = CNT_W'(1);
        end else if (CNT_W'(v) > CNT_MAX) begin
            c = CNT_MAX;
        end
        return c;
    endfunction

endpackage

// File: hdl/identical_koon_reliability.sv
// One item at a time, set by the single shared 30x17 multiplier.
// A write of component_count rebuilds the binomial row, with tready low.
// The next word is taken as soon as the sequencer is back in idle; a finished result
// waits in the output register meanwhile. Reset (synchronous, active low) loads
// n = 2, k = 1 and runs the row rebuild before the first word is taken.
module identical_koon_reliability
    import koon_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,    // [16:0] r
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,    // [16:0] system_reliability
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    // ---------------------------------------------------------------------
    // Sequencer: program counter and the control word it selects.
    // ---------------------------------------------------------------------
    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;
    logic   take;

    // configuration
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_k;

    // datapath
    logic [XW-1:0]     r_r;          // clamped component reliability
    logic [XW-1:0]     r_u;          // ONE - r
    logic [XW-1:0]     r_pw;         // running power
    logic [CNT_W-1:0]  r_i;          // power index / Pascal row
    logic [CNT_W-1:0]  r_w;          // term index / Pascal column
    logic [COEF_W-1:0] r_carry;      // old left neighbor during rebuild
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_out_valid;
    logic [XW-1:0]     r_out_data;

    logic              in_acc;
    logic              out_free;
    logic              cfg_n_we;
    logic [XW-1:0]     in_r;
    logic [XW-1:0]     in_clamped;
    logic [XW-1:0]     pfrac;
    logic [COEF_W-1:0] mul_a;
    logic [XW-1:0]     mul_b;
    logic              w_eq_i;

    logic [XW-1:0]     pu_wdata;
    logic [ADDR_W-1:0] pu_raddr;
    logic [XW-1:0]     pu_rdata;
    logic [COEF_W-1:0] coef_rdata;
    logic [COEF_W-1:0] coef_old;
    logic [COEF_W-1:0] coef_wdata;

    assign uw            = f_ucode(r_upc);
    assign s_axis_tready = (r_upc == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign cfg_n_we      = i_cfg_we && (i_cfg_addr == CFG_COMPONENT_COUNT);

    assign in_r       = s_axis_tdata[XW-1:0];
    assign in_clamped = (in_r > FX_ONE) ? FX_ONE : in_r;

    // Q1.16 part of a product of two values no larger than one
    assign pfrac  = r_prod[FRAC_BITS +: XW];
    assign w_eq_i = (r_w == r_i);

    // ---------------------------------------------------------------------
    // Jump condition; a rewrite of the count restarts the row rebuild.
    // ---------------------------------------------------------------------
    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:   take = 1'b1;
            C_ACCEPT:   take = in_acc;
            C_I_EQ_N:   take = (r_i == r_n);
            C_W_LT_K:   take = (r_w < r_k);
            C_W_EQ_N:   take = (r_w == r_n);
            C_W_EQ_I:   take = w_eq_i;
            C_OUT_FREE: take = out_free;
            default:    take = 1'b0;
        endcase
        if (cfg_n_we) begin
            n_upc = S_L_SEED;
        end else if (take) begin
            n_upc = uw.jt;
        end else begin
            n_upc = uw.jf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_L_SEED;
        end else begin
            r_upc <= n_upc;
        end
    end

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= N_RESET;
            r_k <= K_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_COMPONENT_COUNT) begin
                r_n <= f_clamp_cfg(i_cfg_wdata);
            end else if (i_cfg_addr == CFG_MIN_WORKING) begin
                r_k <= f_clamp_cfg(i_cfg_wdata);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Shared multiplier: one 30x17 product per cycle while mul_en is set, always registered.
    // ---------------------------------------------------------------------
    always_comb begin
        unique case (uw.mula)
            MA_PW:   mul_a = COEF_W'(r_pw);
            MA_COEF: mul_a = coef_rdata;
            default: mul_a = COEF_W'(r_pw);
        endcase
        unique case (uw.mulb)
            MB_U:     mul_b = r_u;
            MB_R:     mul_b = r_r;
            MB_PU:    mul_b = pu_rdata;
            MB_PFRAC: mul_b = pfrac;
            default:  mul_b = r_r;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (uw.mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    // ---------------------------------------------------------------------
    // Counters and working registers. An accepted word seeds the power chain
    // and clears the sum; it and a count write point both counters at entry zero.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_w <= '0;
        end else if (cfg_n_we || in_acc) begin
            r_i <= '0;
            r_w <= '0;
        end else begin
            if (uw.i_op == I_INC) begin
                r_i <= r_i + CNT_W'(1);
            end
            unique case (uw.w_op)
                W_HOLD:  r_w <= r_w;
                W_ZERO:  r_w <= '0;
                W_ONE:   r_w <= CNT_W'(1);
                W_INC:   r_w <= r_w + CNT_W'(1);
                default: r_w <= r_w;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_r   <= in_clamped;
            r_u   <= FX_ONE - in_clamped;
            r_pw  <= FX_ONE;
            r_acc <= '0;
        end else begin
            unique case (uw.pw_op)
                PW_HOLD:  r_pw <= r_pw;
                PW_ONE:   r_pw <= FX_ONE;
                PW_PFRAC: r_pw <= pfrac;
                default:  r_pw <= r_pw;
            endcase
            // the sum cannot pass 2^48, so no saturation is reachable
            if (uw.acc_add) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        unique case (uw.cy_op)
            CY_HOLD: r_carry <= r_carry;
            CY_ONE:  r_carry <= COEF_W'(1);
            CY_OLD:  r_carry <= coef_old;
            default: r_carry <= r_carry;
        endcase
    end

    // ---------------------------------------------------------------------
    // Power table of (1 - r): written in order, read at n - w for each term.
    // ---------------------------------------------------------------------
    assign pu_wdata = (uw.pu_src == PS_PFRAC) ? pfrac : r_pw;
    assign pu_raddr = ADDR_W'(r_n - r_w);

    koon_ram #(
        .DW    (XW),
        .DEPTH (ROW_LEN)
    ) u_pu_ram (
        .i_clk   (i_clk),
        .i_we    (uw.pu_we),
        .i_waddr (r_i),
        .i_wdata (pu_wdata),
        .i_raddr (pu_raddr),
        .o_rdata (pu_rdata)
    );

    // ---------------------------------------------------------------------
    // Binomial row. Rebuild with Pascal's rule, left to right: the new entry
    // is old entry plus old left neighbor; the entry at the row's end has
    // never been part of this row, so read it as zero.
    // ---------------------------------------------------------------------
    assign coef_old   = w_eq_i ? '0 : coef_rdata;
    assign coef_wdata = (uw.coef_src == CS_SUM) ? (coef_old + r_carry) : COEF_W'(1);

    koon_ram #(
        .DW    (COEF_W),
        .DEPTH (ROW_LEN)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (uw.coef_we),
        .i_waddr (r_w),
        .i_wdata (coef_wdata),
        .i_raddr (r_w),
        .o_rdata (coef_rdata)
    );

    // ---------------------------------------------------------------------
    // Output register: clamp the sum to one and hold until taken.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.out_load && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.out_load && out_free) begin
            r_out_data <= (r_acc > ACC_W'(FX_ONE)) ? FX_ONE : r_acc[XW-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_W'(r_out_data);

endmodule

// File: hdl/koon_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; no package needed.
module koon_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/koon_chk.sv
// Port-level checks for identical_koon_reliability, attached by the bind below.
// Depends on koon_pkg for widths and the Q1.16 one.
module koon_chk
    import koon_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [DATA_W-1:0] s_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              i_cfg_we,
    input logic [CFG_AW-1:0] i_cfg_addr,
    input logic [CFG_DW-1:0] i_cfg_wdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // result never exceeds one and the pad bits stay zero
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[XW-1:0] <= FX_ONE)
                          && (m_axis_tdata[DATA_W-1:XW] == '0))
        else $error("result word out of range");

    // one item at a time: an accepted word closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input open right after an accepted word");

    // a count write starts the row rebuild, which closes the input
    a_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_addr == CFG_COMPONENT_COUNT) |=> !s_axis_tready)
        else $error("input open during row rebuild");

endmodule

bind identical_koon_reliability koon_chk u_koon_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_addr    (i_cfg_addr),
    .i_cfg_wdata   (i_cfg_wdata)
);
